/* design/stsc_pkg.sv */
package stsc_pkg;

  // default pointer scaling steps
  localparam int DEF_X_STEPS = 120;
  localparam int DEF_Y_STEPS = 90;

  localparam logic [15:0] RAW_MAX = 16'hFFFF;

  // host command characters
  localparam logic [7:0] CHAR_M    = 8'h4D;
  localparam logic [7:0] CHAR_QRY  = 8'h3F;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // modes
  localparam logic [11:0] MODE_MAX     = 12'd4095;
  localparam logic [11:0] MODE_QUERY   = 12'd1;
  localparam logic [11:0] MODE_TRACK_A = 12'd129;
  localparam logic [11:0] MODE_TRACK_B = 12'd130;

  // report format
  localparam logic [7:0] REPORT_BASE = 8'd64;
  localparam logic [7:0] REPORT_IDLE = 8'h4F;
  localparam int         REPORT_LEN  = 5;

  // jobs waiting between classifier and byte generator
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  host_byte;
    logic [15:0] pointer_x;
    logic [15:0] pointer_y;
    logic [2:0]  buttons;
  } in_word_t;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       last_of_report;
  } out_word_t;

  typedef struct packed {
    logic       left;
    logic [7:0] sx;
    logic [7:0] sy;
  } job_t;

endpackage

/* design/stsc_queue.sv */
module stsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  stsc_pkg::job_t wr_data,
  output logic          full,
  input  logic          pop,
  output stsc_pkg::job_t rd_data,
  output logic          nempty
);

  localparam int DEPTH = stsc_pkg::Q_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  stsc_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign nempty  = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && nempty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/stsc_front.sv */
module stsc_front #(
  parameter int X_STEPS = stsc_pkg::DEF_X_STEPS,
  parameter int Y_STEPS = stsc_pkg::DEF_Y_STEPS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stsc_pkg::in_word_t item,
  output logic              full,
  output logic              q_push,
  output stsc_pkg::job_t    q_data,
  input  logic              q_full
);

  localparam int unsigned XDIV = 65536 / X_STEPS;
  localparam int unsigned YDIV = 65536 / Y_STEPS;
  localparam int unsigned SX_MAX = 65535 / XDIV + 1;
  localparam int unsigned SY_MAX = 65535 / YDIV + 1;
  localparam int SX_W = $clog2(SX_MAX + 1);
  localparam int SY_W = $clog2(SY_MAX + 1);
  // reciprocals scaled by 2^32, quotient estimate is exact or one low
  localparam longint unsigned RECIP_X = 64'h1_0000_0000 / XDIV;
  localparam longint unsigned RECIP_Y = 64'h1_0000_0000 / YDIV;
  localparam int RX_W = $clog2(RECIP_X + 1);
  localparam int RY_W = $clog2(RECIP_Y + 1);
  localparam int PX_W = 16 + RX_W;
  localparam int PY_W = 16 + RY_W;

  localparam logic [RX_W-1:0] RX = RX_W'(RECIP_X);
  localparam logic [RY_W-1:0] RY = RY_W'(RECIP_Y);
  localparam logic [15:0] XD = 16'(XDIV);
  localparam logic [15:0] YD = 16'(YDIV);

  logic        accept;
  logic        adv;

  // mode register and its update
  logic [11:0] mode;
  logic [11:0] mode_next;
  logic [3:0]  digit;
  logic [15:0] mode_x10;
  logic        in_query;
  logic        in_auto;

  // stage 1
  logic            s1_valid;
  logic            s1_query;
  logic            s1_auto;
  logic [2:0]      s1_btn;
  logic [15:0]     s1_nx;
  logic [15:0]     s1_ny;
  logic [PX_W-1:0] s1_px;
  logic [PY_W-1:0] s1_py;

  // stage 2 combinational
  logic [SX_W-1:0] qx_est;
  logic [SY_W-1:0] qy_est;
  logic [SX_W+15:0] qx_d;
  logic [SY_W+15:0] qy_d;
  logic [15:0]     rx;
  logic [15:0]     ry;
  logic [SX_W-1:0] sx_calc;
  logic [SY_W-1:0] sy_calc;

  // stage 2
  logic            s2_valid;
  logic            s2_query;
  logic            s2_auto;
  logic [2:0]      s2_btn;
  logic [SX_W-1:0] s2_sx;
  logic [SY_W-1:0] s2_sy;
  logic            s2_change;
  logic            s2_report;

  // last report
  logic            never_reported;
  logic [SX_W-1:0] prev_x;
  logic [SY_W-1:0] prev_y;
  logic [2:0]      prev_buttons;

  assign adv    = !(s2_valid && s2_report && q_full);
  assign full   = !adv;
  assign accept = push && adv;

  assign digit    = 4'(item.host_byte - stsc_pkg::CHAR_0);
  assign mode_x10 = ({4'd0, mode} << 3) + ({4'd0, mode} << 1) + {12'd0, digit};

  always_comb begin
    mode_next = mode;
    if (!item.cmd) begin
      if (item.host_byte == stsc_pkg::CHAR_M) begin
        mode_next = '0;
      end else if (item.host_byte inside {[stsc_pkg::CHAR_0:stsc_pkg::CHAR_9]}) begin
        mode_next = (mode_x10 > {4'd0, stsc_pkg::MODE_MAX}) ? stsc_pkg::MODE_MAX
                                                             : mode_x10[11:0];
      end
    end
  end

  assign in_query = !item.cmd && (item.host_byte == stsc_pkg::CHAR_QRY)
                    && (mode == stsc_pkg::MODE_QUERY);
  assign in_auto  = (mode_next == stsc_pkg::MODE_TRACK_A)
                    || (mode_next == stsc_pkg::MODE_TRACK_B);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

  // stage 1: reciprocal products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_query <= in_query;
      s1_auto  <= in_auto;
      s1_btn   <= item.buttons;
      s1_nx    <= stsc_pkg::RAW_MAX - item.pointer_x;
      s1_ny    <= item.pointer_y;
      s1_px    <= (stsc_pkg::RAW_MAX - item.pointer_x) * RX;
      s1_py    <= item.pointer_y * RY;
    end
  end

  // stage 2: remainder check corrects the estimate
  assign qx_est  = SX_W'(s1_px >> 32);
  assign qy_est  = SY_W'(s1_py >> 32);
  assign qx_d    = qx_est * XD;
  assign qy_d    = qy_est * YD;
  assign rx      = s1_nx - qx_d[15:0];
  assign ry      = s1_ny - qy_d[15:0];
  assign sx_calc = qx_est + SX_W'(1) + SX_W'(rx >= XD);
  assign sy_calc = qy_est + SY_W'(1) + SY_W'(ry >= YD);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_query <= s1_query;
      s2_auto  <= s1_auto;
      s2_btn   <= s1_btn;
      s2_sx    <= sx_calc;
      s2_sy    <= sy_calc;
    end
  end

  assign s2_change = never_reported || (s2_sx != prev_x) || (s2_sy != prev_y)
                     || (s2_btn != prev_buttons);
  assign s2_report = s2_query || (s2_auto && s2_change);

  assign q_push    = s2_valid && s2_report && !q_full;
  assign q_data.left = s2_btn[0];
  assign q_data.sx   = 8'(s2_sx);
  assign q_data.sy   = 8'(s2_sy);

  always_ff @(posedge clk) begin
    if (rst) begin
      never_reported <= 1'b1;
      prev_x         <= '0;
      prev_y         <= '0;
      prev_buttons   <= '0;
    end else if (q_push) begin
      never_reported <= 1'b0;
      prev_x         <= s2_sx;
      prev_y         <= s2_sy;
      prev_buttons   <= s2_btn;
    end
  end

endmodule

/* design/stsc_back.sv */
module stsc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nempty,
  input  stsc_pkg::job_t     q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output stsc_pkg::out_word_t result
);

  localparam int IW = $clog2(stsc_pkg::REPORT_LEN);
  localparam logic [IW-1:0] LAST_IDX = IW'(stsc_pkg::REPORT_LEN - 1);

  logic           busy;
  logic [IW-1:0]  idx;
  stsc_pkg::job_t job;
  logic           taken;
  logic           done;

  assign taken = pop && busy;
  assign done  = taken && (idx == LAST_IDX);
  assign q_pop = q_nempty && (!busy || done);
  assign empty = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (done) begin
        busy <= 1'b0;
        idx  <= '0;
      end else if (taken) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
  end

  // byte order: x high, x low, y high, y low, terminator
  always_comb begin
    result.last_of_report = (idx == LAST_IDX);
    case (idx)
      IW'(0):  result.report_byte = job.left ? stsc_pkg::REPORT_BASE + {4'd0, job.sx[7:4]}
                                             : stsc_pkg::REPORT_IDLE;
      IW'(1):  result.report_byte = job.left ? stsc_pkg::REPORT_BASE + {4'd0, job.sx[3:0]}
                                             : stsc_pkg::REPORT_IDLE;
      IW'(2):  result.report_byte = job.left ? stsc_pkg::REPORT_BASE + {4'd0, job.sy[7:4]}
                                             : stsc_pkg::REPORT_IDLE;
      IW'(3):  result.report_byte = job.left ? stsc_pkg::REPORT_BASE + {4'd0, job.sy[3:0]}
                                             : stsc_pkg::REPORT_IDLE;
      default: result.report_byte = stsc_pkg::CHAR_DOT;
    endcase
  end

endmodule

/* design/serial_touch_screen_controller.sv */
// serial touch-screen controller
// input channel (push/full): one word per host command byte or poll tick,
// each carrying the pointer position and buttons; taken when push is high
// and full is low. one word can be taken every cycle while full stays low.
// result channel (empty/pop): report bytes, five per report, the last one
// flagged by last_of_report; the byte on result is taken when pop is high
// and empty is low.
// a taken word passes a two-stage scaling pipeline (reciprocal multiply,
// then remainder correction) and the report decision; a report job then
// waits in a four-entry queue for the byte generator. with everything idle
// the first report byte shows once the word has passed both stages and the
// queue and its job is registered in the byte generator; the remaining four
// bytes follow one per cycle of pop. sustained rate: one word per cycle
// while no reports are made; reports drain at the one-byte-per-cycle output.
// when pop is held low the queue fills and full rises as soon as a word
// that must report reaches the end of the pipeline.
// reset clears the mode, the queue and the pending output, and arms the
// first report so that it is sent whatever the previous position.
module serial_touch_screen_controller #(
  parameter int X_STEPS = stsc_pkg::DEF_X_STEPS,
  parameter int Y_STEPS = stsc_pkg::DEF_Y_STEPS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  stsc_pkg::in_word_t  item,
  output logic                empty,
  input  logic                pop,
  output stsc_pkg::out_word_t result
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_nempty;
  stsc_pkg::job_t q_wr;
  stsc_pkg::job_t q_rd;

  stsc_front #(
    .X_STEPS (X_STEPS),
    .Y_STEPS (Y_STEPS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_push (q_push),
    .q_data (q_wr),
    .q_full (q_full)
  );

  stsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .nempty  (q_nempty)
  );

  stsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_nempty (q_nempty),
    .q_data   (q_rd),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
